/* rtl/mm_pkg.sv */
`timescale 1ns / 1ps
package mm_pkg;

  // Widths fixed by the item format.
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned DIM_W  = 4;
  localparam int unsigned CIDX_W = 3;

  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_NONE    = 2'd3
  } mm_mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_SIZE = 2'd2
  } mm_status_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_A_ROWS = 3'd0,
    REG_A_COLS = 3'd1,
    REG_B_ROWS = 3'd2,
    REG_B_COLS = 3'd3
  } mm_reg_e;

  // Control tag that travels alongside each multiply-accumulate step.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic             last;
    logic             err;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mm_tag_t;

endpackage

/* rtl/mm_ram.sv */
`timescale 1ns / 1ps
module mm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mm_mac.sv */
`timescale 1ns / 1ps
module mm_mac import mm_pkg::*; #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mm_tag_t                  tag_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic signed [ELEM_W-1:0] b_i,
  input  logic                     out_ready_i,
  output logic                     adv_o,
  output logic                     out_valid_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [ELEM_W-1:0] out_value_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  mm_tag_t tag1_q, tag2_q, tag3_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d, shifted;
  logic                     fin, adv, fits;
  logic [ACC_W-1:31]        upper;
  logic [ELEM_W-1:0]        sat_val;

  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic [ELEM_W-1:0]        out_value_q;
  logic [1:0]               status_q;
  logic                     last_q;

  // The last step of an element leaves stage three; it needs the output word free.
  assign fin = tag3_q.valid && tag3_q.lastk;
  assign adv = !(fin && out_valid_q && !out_ready_i);

  assign acc_d = (tag2_q.first ? '0 : acc_q)
               + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  assign shifted = acc_q >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:31];
  assign fits    = (&upper) || !(|upper);
  assign sat_val = shifted[ACC_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
                                    : {1'b0, {(ELEM_W-1){1'b1}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q      <= '0;
      tag2_q      <= '0;
      tag3_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        tag1_q <= tag_i;
        tag2_q <= tag1_q;
        tag3_q <= tag2_q;
      end
      if (adv && fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
      if (tag2_q.valid) begin
        acc_q <= acc_d;
      end
    end
    if (adv && fin) begin
      last_q <= tag3_q.last;
      if (tag3_q.err) begin
        out_row_q   <= '0;
        out_col_q   <= '0;
        out_value_q <= '0;
        status_q    <= ST_SIZE;
      end else begin
        out_row_q   <= tag3_q.row;
        out_col_q   <= tag3_q.col;
        out_value_q <= fits ? shifted[ELEM_W-1:0] : sat_val;
        status_q    <= fits ? ST_OK : ST_SAT;
      end
    end
  end

  assign adv_o       = adv;
  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

/* rtl/matrix_multiply_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Contents
// in        sink       in_valid_i/in_ready_o  mode, row_index, col_index, elem_value
// out       source     out_valid_o/out_ready_i out_row, out_col, out_value, status, last
// cfg       sink       cfg_we_i               cfg_index_i, cfg_wdata_i
//
// A load word writes the A or B element memory directly. A compute word with
// a_cols equal to b_rows issues one multiply-accumulate per cycle while the
// pipeline advances, through the single read port of each memory; the last
// product element passes the read data, product, accumulator and output registers.
// Reset sets all four dimensions to eight; the element memories are not cleared.
// A stalled output word halts the pipeline once the next finished element reaches its end.
module matrix_multiply_top import mm_pkg::*; #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CIDX_W-1:0]        cfg_index_i,
  input  logic [DIM_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [IDX_W-1:0]         row_index_i,
  input  logic [IDX_W-1:0]         col_index_i,
  input  logic signed [ELEM_W-1:0] elem_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [ELEM_W-1:0] out_value_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_ERR
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] i_q, j_q, k_q;
  logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [DIM_W-1:0] n_dim, m_dim, p_dim, q_dim;
  logic             accept, wr_ok, last_k, last_j, last_i, adv;
  logic [AW-1:0]    waddr, a_raddr, b_raddr;
  mm_tag_t          tag;
  logic [ELEM_W-1:0] a_data, b_data;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign n_dim = eff_dim(a_rows_q);
  assign m_dim = eff_dim(a_cols_q);
  assign p_dim = eff_dim(b_rows_q);
  assign q_dim = eff_dim(b_cols_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign wr_ok = (int'(row_index_i) < MAX_DIM) && (int'(col_index_i) < MAX_DIM);
  assign waddr = AW'(int'(row_index_i) * MAX_DIM + int'(col_index_i));

  assign a_raddr = AW'(int'(i_q) * MAX_DIM + int'(k_q));
  assign b_raddr = AW'(int'(k_q) * MAX_DIM + int'(j_q));

  assign last_k = ({1'b0, k_q} + DIM_W'(1)) == m_dim;
  assign last_j = ({1'b0, j_q} + DIM_W'(1)) == q_dim;
  assign last_i = ({1'b0, i_q} + DIM_W'(1)) == n_dim;

  always_comb begin
    tag = '0;
    unique case (state_q)
      S_RUN: begin
        tag.valid = 1'b1;
        tag.first = (k_q == '0);
        tag.lastk = last_k;
        tag.last  = last_i && last_j;
        tag.row   = i_q;
        tag.col   = j_q;
      end
      S_ERR: begin
        tag.valid = 1'b1;
        tag.first = 1'b1;
        tag.lastk = 1'b1;
        tag.last  = 1'b1;
        tag.err   = 1'b1;
      end
      default: begin
        tag = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= DIM_W'(8);
      a_cols_q <= DIM_W'(8);
      b_rows_q <= DIM_W'(8);
      b_cols_q <= DIM_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_A_ROWS: a_rows_q <= cfg_wdata_i;
        REG_A_COLS: a_cols_q <= cfg_wdata_i;
        REG_B_ROWS: b_rows_q <= cfg_wdata_i;
        REG_B_COLS: b_cols_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer: walks i, j and the inner index k, one step per advancing cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          i_q <= '0;
          j_q <= '0;
          k_q <= '0;
          if (accept && (mode_i == MODE_COMPUTE)) begin
            state_q <= (m_dim != p_dim) ? S_ERR : S_RUN;
          end
        end
        S_RUN: begin
          if (adv) begin
            if (!last_k) begin
              k_q <= k_q + IDX_W'(1);
            end else begin
              k_q <= '0;
              if (!last_j) begin
                j_q <= j_q + IDX_W'(1);
              end else begin
                j_q <= '0;
                if (!last_i) begin
                  i_q <= i_q + IDX_W'(1);
                end else begin
                  state_q <= S_IDLE;
                end
              end
            end
          end
        end
        S_ERR: begin
          if (adv) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  mm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (accept && (mode_i == MODE_LOAD_A) && wr_ok),
    .waddr_i (waddr),
    .wdata_i (elem_value_i),
    .re_i    (adv),
    .raddr_i (a_raddr),
    .rdata_o (a_data)
  );

  mm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (accept && (mode_i == MODE_LOAD_B) && wr_ok),
    .waddr_i (waddr),
    .wdata_i (elem_value_i),
    .re_i    (adv),
    .raddr_i (b_raddr),
    .rdata_o (b_data)
  );

  mm_mac #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .a_i         (a_data),
    .b_i         (b_data),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .out_value_o (out_value_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import mm_pkg::*;

  localparam int unsigned DIM_MAX       = 8;
  localparam int unsigned FRAC          = 16;
  localparam int unsigned STORE_DEPTH   = DIM_MAX * DIM_MAX;
  localparam int unsigned RANDOM_WORDS  = 350;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned PRINT_LIMIT   = 100;

  // First register index past the four dimension registers.
  localparam logic [CIDX_W-1:0] REG_SPARE_FIRST = 3'd4;

  localparam logic signed [ELEM_W-1:0] Q_POS_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [ELEM_W-1:0] Q_NEG_MAX   = 32'sh8000_0000;
  localparam logic signed [ELEM_W-1:0] Q_ONE       = 32'sh0001_0000;
  localparam logic signed [ELEM_W-1:0] Q_LSB       = 32'sh0000_0001;
  localparam logic signed [ELEM_W-1:0] Q_MINUS_LSB = 32'shFFFF_FFFF;
  localparam logic signed [69:0]       SUM_MAX     = 70'sh7FFF_FFFF;
  localparam logic signed [69:0]       SUM_MIN     = -70'sh8000_0000;

  typedef struct {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [ELEM_W-1:0] value;
    mm_status_e               status;
    logic                     last;
  } product_elem_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_style_e;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_we_i     = 1'b0;
  logic [CIDX_W-1:0]        cfg_index_i  = '0;
  logic [DIM_W-1:0]         cfg_wdata_i  = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               mode_i       = MODE_NONE;
  logic [IDX_W-1:0]         row_index_i  = '0;
  logic [IDX_W-1:0]         col_index_i  = '0;
  logic signed [ELEM_W-1:0] elem_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic [IDX_W-1:0]         out_row_o;
  logic [IDX_W-1:0]         out_col_o;
  logic signed [ELEM_W-1:0] out_value_o;
  logic [1:0]               status_o;
  logic                     last_o;

  // Mirror of the block: element stores, which entries hold data, dimensions.
  logic signed [ELEM_W-1:0] elem_a [STORE_DEPTH];
  logic signed [ELEM_W-1:0] elem_b [STORE_DEPTH];
  bit                       loaded_a [STORE_DEPTH];
  bit                       loaded_b [STORE_DEPTH];
  logic [DIM_W-1:0]         dim_reg [4] = '{4'd8, 4'd8, 4'd8, 4'd8};

  product_elem_t pending_elements [$];

  int unsigned  mismatch_count = 0;
  int unsigned  words_sent     = 0;
  int unsigned  burst_left     = 0;
  int unsigned  idle_cycles    = 0;
  int unsigned  stall_span     = 0;
  ready_style_e stall_style    = READY_ALWAYS;

  matrix_multiply_top #(
    .MAX_DIM  (DIM_MAX),
    .FRAC_BITS(FRAC)
  ) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned effective_dim(logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM_MAX) return DIM_MAX;
    return 32'(raw);
  endfunction

  // Exact sums of products, then floor shift and saturation to 32 bits; a size mismatch gives one ST_SIZE element.
  function automatic void compute_product_elements();
    int unsigned   rows;
    int unsigned   inner;
    int unsigned   inner_b;
    int unsigned   cols;
    logic signed [69:0] acc;
    logic signed [69:0] xa;
    logic signed [69:0] xb;
    logic signed [69:0] scaled;
    product_elem_t elem;
    rows    = effective_dim(dim_reg[REG_A_ROWS]);
    inner   = effective_dim(dim_reg[REG_A_COLS]);
    inner_b = effective_dim(dim_reg[REG_B_ROWS]);
    cols    = effective_dim(dim_reg[REG_B_COLS]);
    if (inner != inner_b) begin
      elem.row    = '0;
      elem.col    = '0;
      elem.value  = '0;
      elem.status = ST_SIZE;
      elem.last   = 1'b1;
      pending_elements.push_back(elem);
      return;
    end
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        acc = '0;
        for (int k = 0; k < inner; k++) begin
          xa  = 70'(elem_a[i * DIM_MAX + k]);
          xb  = 70'(elem_b[k * DIM_MAX + j]);
          acc = acc + xa * xb;
        end
        scaled      = acc >>> FRAC;
        elem.row    = IDX_W'(i);
        elem.col    = IDX_W'(j);
        elem.status = ST_OK;
        elem.last   = (i == rows - 1) && (j == cols - 1);
        if (scaled > SUM_MAX) begin
          elem.value  = Q_POS_MAX;
          elem.status = ST_SAT;
        end else if (scaled < SUM_MIN) begin
          elem.value  = Q_NEG_MAX;
          elem.status = ST_SAT;
        end else begin
          elem.value = scaled[ELEM_W-1:0];
        end
        pending_elements.push_back(elem);
      end
    end
  endfunction

  function automatic void record_accepted_word(mm_mode_e mode, logic [IDX_W-1:0] row,
                                               logic [IDX_W-1:0] col,
                                               logic signed [ELEM_W-1:0] value);
    int unsigned slot;
    slot = row * DIM_MAX + col;
    case (mode)
      MODE_LOAD_A: begin
        elem_a[slot]   = value;
        loaded_a[slot] = 1'b1;
      end
      MODE_LOAD_B: begin
        elem_b[slot]   = value;
        loaded_b[slot] = 1'b1;
      end
      MODE_COMPUTE: compute_product_elements();
      default: ;
    endcase
  endfunction

  function automatic logic signed [ELEM_W-1:0] random_element();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return Q_POS_MAX;
          1: return Q_NEG_MAX;
          2: return '0;
          3: return Q_MINUS_LSB;
          default: return Q_ONE;
        endcase
      end
      // Up to 64.0 in magnitude, so full-length sums sit near the saturation edge.
      3, 4: return $signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000;
      default: return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
    endcase
  endfunction

  // Zero reads as one and anything above eight as eight, so both encodings are used.
  function automatic logic [DIM_W-1:0] encode_dim(int unsigned dim);
    if (dim == 1 && $urandom_range(0, 3) == 0) return '0;
    if (dim == DIM_MAX && $urandom_range(0, 2) == 0) begin
      return DIM_W'($urandom_range(DIM_MAX + 1, 2 ** DIM_W - 1));
    end
    return DIM_W'(dim);
  endfunction

  function automatic bit operands_ready(int unsigned rows, int unsigned inner,
                                        int unsigned cols);
    for (int i = 0; i < rows; i++) begin
      for (int k = 0; k < inner; k++) begin
        if (!loaded_a[i * DIM_MAX + k]) return 1'b0;
      end
    end
    for (int k = 0; k < inner; k++) begin
      for (int j = 0; j < cols; j++) begin
        if (!loaded_b[k * DIM_MAX + j]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string field, logic [ELEM_W-1:0] got,
                                 logic [ELEM_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t: %s is %0h, expected %0h", $time, field, got, want);
    end
  endtask

  // Valid drops only at the end of a burst; a new burst always starts after a gap.
  task automatic send_word(mm_mode_e mode, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                           logic signed [ELEM_W-1:0] value);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 4))
        @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    row_index_i  <= row;
    col_index_i  <= col;
    elem_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    record_accepted_word(mode, row, col, value);
    if (mode != MODE_NONE) words_sent++;
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic close_burst();
    if (burst_left != 0) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic wait_block_idle();
    close_burst();
    while (pending_elements.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dim_reg(logic [CIDX_W-1:0] index, logic [DIM_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index <= REG_B_COLS) dim_reg[index] = value;
  endtask

  task automatic send_noise_word();
    case ($urandom_range(0, 3))
      0, 1: send_word(MODE_NONE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      2: send_word(MODE_LOAD_A, IDX_W'($urandom), IDX_W'($urandom), random_element());
      default: send_word(MODE_LOAD_B, IDX_W'($urandom), IDX_W'($urandom), random_element());
    endcase
  endtask

  // Loads every operand entry that a compute will read, in shuffled order. Entries
  // already loaded are reloaded with the given percentage.
  task automatic load_operands(int unsigned rows, int unsigned inner, int unsigned cols,
                               int unsigned refresh_pct);
    int unsigned slots [$];
    int unsigned slot;
    int unsigned pick;
    for (int i = 0; i < rows; i++) begin
      for (int k = 0; k < inner; k++) begin
        slot = i * DIM_MAX + k;
        if (!loaded_a[slot] || $urandom_range(1, 100) <= refresh_pct) slots.push_back(slot);
      end
    end
    for (int k = 0; k < inner; k++) begin
      for (int j = 0; j < cols; j++) begin
        slot = k * DIM_MAX + j;
        if (!loaded_b[slot] || $urandom_range(1, 100) <= refresh_pct) begin
          slots.push_back(STORE_DEPTH + slot);
        end
      end
    end
    for (int s = slots.size() - 1; s > 0; s--) begin
      pick        = $urandom_range(0, s);
      slot        = slots[s];
      slots[s]    = slots[pick];
      slots[pick] = slot;
    end
    foreach (slots[s]) begin
      if ($urandom_range(0, 9) == 0) send_noise_word();
      // An early compute on half-refreshed operands, once every entry holds data.
      if ($urandom_range(0, 24) == 0 && operands_ready(rows, inner, cols)) begin
        send_word(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      end
      slot = slots[s] % STORE_DEPTH;
      if (slots[s] >= STORE_DEPTH) begin
        send_word(MODE_LOAD_B, IDX_W'(slot / DIM_MAX), IDX_W'(slot % DIM_MAX),
                  random_element());
      end else begin
        send_word(MODE_LOAD_A, IDX_W'(slot / DIM_MAX), IDX_W'(slot % DIM_MAX),
                  random_element());
      end
    end
  endtask

  task automatic run_product_phase(int unsigned rows, int unsigned inner, int unsigned cols,
                                   bit size_error, int unsigned refresh_pct);
    int unsigned inner_b;
    inner_b = inner;
    if (size_error) begin
      while (inner_b == inner) inner_b = $urandom_range(1, DIM_MAX);
    end
    wait_block_idle();
    write_dim_reg(REG_A_ROWS, encode_dim(rows));
    write_dim_reg(REG_A_COLS, encode_dim(inner));
    write_dim_reg(REG_B_ROWS, encode_dim(inner_b));
    write_dim_reg(REG_B_COLS, encode_dim(cols));
    if ($urandom_range(0, 7) == 0) begin
      write_dim_reg(CIDX_W'($urandom_range(REG_SPARE_FIRST, 2 ** CIDX_W - 1)),
                    DIM_W'($urandom));
    end
    load_operands(rows, inner, cols, refresh_pct);
    repeat ($urandom_range(1, 2)) begin
      send_word(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
      if ($urandom_range(0, 2) == 0) load_operands(rows, inner, cols, 30);
    end
  endtask

  // One by one products on the saturation edges and the floor rounding.
  task automatic test_corner_products();
    write_dim_reg(REG_A_ROWS, '0);
    write_dim_reg(REG_A_COLS, '0);
    write_dim_reg(REG_B_ROWS, '0);
    write_dim_reg(REG_B_COLS, '0);
    send_word(MODE_LOAD_A, '0, '0, Q_POS_MAX);
    send_word(MODE_LOAD_B, '0, '0, Q_POS_MAX);
    send_word(MODE_COMPUTE, '1, '1, Q_NEG_MAX);
    send_word(MODE_LOAD_A, '0, '0, Q_NEG_MAX);
    send_word(MODE_COMPUTE, '0, '0, '0);
    // Lands exactly on the most negative value without saturating.
    send_word(MODE_LOAD_B, '0, '0, Q_ONE);
    send_word(MODE_COMPUTE, '0, '0, '0);
    send_word(MODE_LOAD_B, '0, '0, Q_NEG_MAX);
    send_word(MODE_COMPUTE, '0, '0, '0);
    // Minus one LSB times one LSB must floor to minus one LSB, not to zero.
    send_word(MODE_LOAD_A, '0, '0, Q_MINUS_LSB);
    send_word(MODE_LOAD_B, '0, '0, Q_LSB);
    send_word(MODE_COMPUTE, '0, '0, '0);
    send_word(MODE_LOAD_A, '0, '0, '0);
    send_word(MODE_COMPUTE, '0, '0, '0);
    send_word(MODE_NONE, '1, '1, Q_MINUS_LSB);
    send_word(MODE_LOAD_A, '1, '1, Q_POS_MAX);
    send_word(MODE_LOAD_B, '1, '1, Q_NEG_MAX);
  endtask

  task automatic test_register_decode();
    wait_block_idle();
    write_dim_reg(REG_A_ROWS, 4'd1);
    write_dim_reg(REG_A_COLS, 4'd1);
    write_dim_reg(REG_B_ROWS, 4'd1);
    write_dim_reg(REG_B_COLS, 4'd1);
    // Writes past the last register must not alias onto a dimension.
    for (int idx = REG_SPARE_FIRST; idx < 2 ** CIDX_W; idx++) begin
      write_dim_reg(CIDX_W'(idx), 4'd5);
    end
    send_word(MODE_LOAD_A, '0, '0, random_element());
    send_word(MODE_COMPUTE, '0, '0, '0);
    wait_block_idle();
    write_dim_reg(REG_A_COLS, 4'd2);
    write_dim_reg(REG_B_ROWS, 4'd3);
    send_word(MODE_COMPUTE, '1, '1, '1);
    wait_block_idle();
    write_dim_reg(REG_A_ROWS, 4'hF);
    write_dim_reg(REG_A_COLS, 4'hF);
    write_dim_reg(REG_B_ROWS, 4'h0);
    write_dim_reg(REG_B_COLS, 4'hA);
    send_word(MODE_COMPUTE, '0, '0, '0);
  endtask

  task automatic test_random_products();
    int unsigned start_count;
    int unsigned rows;
    int unsigned inner;
    int unsigned cols;
    int unsigned style;
    start_count = words_sent;
    run_product_phase(DIM_MAX, DIM_MAX, DIM_MAX, 1'b0, 10);
    while (words_sent - start_count < RANDOM_WORDS) begin
      style = $urandom_range(0, 19);
      if (style < 2) begin
        rows  = DIM_MAX;
        inner = 1;
        cols  = DIM_MAX;
      end else if (style < 4) begin
        rows  = 1;
        inner = DIM_MAX;
        cols  = 1;
      end else if (style < 7) begin
        rows  = $urandom_range(1, 5);
        inner = $urandom_range(1, 5);
        cols  = $urandom_range(1, 5);
      end else begin
        rows  = $urandom_range(1, 3);
        inner = $urandom_range(1, 3);
        cols  = $urandom_range(1, 3);
      end
      run_product_phase(rows, inner, cols, $urandom_range(0, 9) == 0, 100);
    end
  endtask

  always @(posedge clk_i) begin : check_products
    product_elem_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_elements.size() == 0) begin
        report_mismatch("unexpected word at row/col", ELEM_W'({out_row_o, out_col_o}), '0);
      end else begin
        want = pending_elements.pop_front();
        if (out_row_o !== want.row) begin
          report_mismatch("out_row", ELEM_W'(out_row_o), ELEM_W'(want.row));
        end
        if (out_col_o !== want.col) begin
          report_mismatch("out_col", ELEM_W'(out_col_o), ELEM_W'(want.col));
        end
        if (out_value_o !== want.value) report_mismatch("out_value", out_value_o, want.value);
        if (status_o !== want.status) begin
          report_mismatch("status", ELEM_W'(status_o), ELEM_W'(want.status));
        end
        if (last_o !== want.last) begin
          report_mismatch("last", ELEM_W'(last_o), ELEM_W'(want.last));
        end
      end
    end
  end

  // The receiver switches at random between stall patterns.
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_style = ready_style_e'($urandom_range(0, 3));
      stall_span  = $urandom_range(16, 160);
    end else begin
      stall_span--;
    end
    case (stall_style)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready_i <= ($urandom_range(0, 5) == 0);
      default:      out_ready_i <= (stall_span % 4 != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_products();
    test_register_decode();
    test_random_products();
    wait_block_idle();
    if (mismatch_count == 0 && pending_elements.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mm_pkg.sv
rtl/mm_ram.sv
rtl/mm_mac.sv
rtl/matrix_multiply_top.sv
verif/testbench.sv
